/* rtl/lts_pkg.sv */
// shared types, widths and codes for the token scanner
`timescale 1ns / 1ps

package lts_pkg;

  // field widths
  localparam int CHAR_BITS   = 8;
  localparam int KIND_BITS   = 5;
  localparam int ERR_BITS    = 3;
  localparam int LINE_BITS   = 20;
  localparam int COLUMN_BITS = 16;
  localparam int LEN_BITS    = 16;

  // result queue geometry (depth is a power of two)
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
  localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);
  localparam logic [LEN_BITS-1:0]    LEN_ONE  = LEN_BITS'(1);

  // token kinds
  localparam logic [KIND_BITS-1:0] K_OPEN    = 5'd0;
  localparam logic [KIND_BITS-1:0] K_CLOSE   = 5'd1;
  localparam logic [KIND_BITS-1:0] K_QUOTE   = 5'd2;
  localparam logic [KIND_BITS-1:0] K_SYMBOL  = 5'd3;
  localparam logic [KIND_BITS-1:0] K_NUMBER  = 5'd4;
  localparam logic [KIND_BITS-1:0] K_STRING  = 5'd5;
  localparam logic [KIND_BITS-1:0] K_ERROR   = 5'd6;
  localparam logic [KIND_BITS-1:0] K_LT      = 5'd7;
  localparam logic [KIND_BITS-1:0] K_GT      = 5'd8;
  localparam logic [KIND_BITS-1:0] K_EQ      = 5'd9;
  localparam logic [KIND_BITS-1:0] K_LEQ     = 5'd10;
  localparam logic [KIND_BITS-1:0] K_GEQ     = 5'd11;
  localparam logic [KIND_BITS-1:0] K_NEQ     = 5'd12;
  localparam logic [KIND_BITS-1:0] K_PLUS    = 5'd13;
  localparam logic [KIND_BITS-1:0] K_MINUS   = 5'd14;
  localparam logic [KIND_BITS-1:0] K_STAR    = 5'd15;
  localparam logic [KIND_BITS-1:0] K_SLASH   = 5'd16;
  localparam logic [KIND_BITS-1:0] K_PERCENT = 5'd17;

  // error codes
  localparam logic [ERR_BITS-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERR_BITS-1:0] ERR_INVALID   = 3'd1;
  localparam logic [ERR_BITS-1:0] ERR_MULTI_PT  = 3'd2;
  localparam logic [ERR_BITS-1:0] ERR_TRAIL_PT  = 3'd3;
  localparam logic [ERR_BITS-1:0] ERR_OPEN_STR  = 3'd4;

  // characters
  localparam logic [CHAR_BITS-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_BANG   = 8'h21;
  localparam logic [CHAR_BITS-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_BITS-1:0] CH_PCT    = 8'h25;
  localparam logic [CHAR_BITS-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_BITS-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_BITS-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_BITS-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_BITS-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_POINT  = 8'h2E;
  localparam logic [CHAR_BITS-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_BITS-1:0] CH_LT     = 8'h3C;
  localparam logic [CHAR_BITS-1:0] CH_EQUAL  = 8'h3D;
  localparam logic [CHAR_BITS-1:0] CH_GT     = 8'h3E;
  localparam logic [CHAR_BITS-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CHAR_BITS-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LO_Z   = 8'h7A;

  // one token record
  typedef struct packed {
    logic [KIND_BITS-1:0]   token_kind;
    logic [ERR_BITS-1:0]    error_code;
    logic [LINE_BITS-1:0]   start_line;
    logic [COLUMN_BITS-1:0] start_column;
    logic [LEN_BITS-1:0]    token_length;
    logic                   run_end;
  } result_t;

  // up to two records produced by one character
  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

/* rtl/lts_if.sv */
// channel interfaces for characters in and token records out
`timescale 1ns / 1ps

interface lts_in_if;
  import lts_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] char_code;
  logic                 final_char;

  modport source (output valid, output char_code, output final_char, input ready);
  modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

interface lts_out_if;
  import lts_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [KIND_BITS-1:0]   token_kind;
  logic [ERR_BITS-1:0]    error_code;
  logic [LINE_BITS-1:0]   start_line;
  logic [COLUMN_BITS-1:0] start_column;
  logic [LEN_BITS-1:0]    token_length;
  logic                   run_end;

  modport source (output valid, output token_kind, output error_code, output start_line,
                  output start_column, output token_length, output run_end, input ready);
  modport sink   (input valid, input token_kind, input error_code, input start_line,
                  input start_column, input token_length, input run_end, output ready);
endinterface

/* rtl/lisp_token_scanner.sv */
// top level of the character-stream token scanner
//
// Usage:
//   in_ch  carries one character per transfer (char_code) and final_char,
//          which marks the last character of an input; after it the scanner
//          flushes any pending token and restarts at line 1, column 1.
//   out_ch carries token records: kind, error code, start line and column,
//          length, and run_end on the last record caused by a character.
// Timing:
//   A character transfers into an input register and is scanned from there
//   once the result queue has room; its records become visible on out_ch in
//   the cycle after the scan. One character is taken per cycle; a character
//   is scanned only when the four-entry result queue has room for two
//   records, so one character per cycle holds while the receiver keeps up;
//   even when out_ch takes one record per cycle, characters that yield two
//   records each fill the queue and stall the input.
// Reset (rst_n low, synchronous) empties the queue and the input register
//   and returns the scanner to idle at line 1, column 1.
// When out_ch stalls, the queue fills, then the input register holds and
//   in_ch.ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module lisp_token_scanner (
  input  logic            clk,
  input  logic            rst_n,
  lts_in_if.sink          in_ch,
  lts_out_if.source       out_ch
);
  import lts_pkg::*;

  logic                 s1_valid_r, s1_valid_nxt;
  logic [CHAR_BITS-1:0] s1_char_r;
  logic                 s1_fin_r;
  logic                 room;
  logic                 go;
  logic                 in_xfer;
  push_t                push;
  result_t              head;

  // input register stage
  assign go          = s1_valid_r && room;
  assign in_ch.ready = !s1_valid_r || room;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_char_r <= in_ch.char_code;
      s1_fin_r  <= in_ch.final_char;
    end
  end

  // scanner
  lts_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .char_code  (s1_char_r),
    .final_char (s1_fin_r),
    .push       (push)
  );

  // result queue
  lts_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (head)
  );

  // output payload
  assign out_ch.token_kind   = head.token_kind;
  assign out_ch.error_code   = head.error_code;
  assign out_ch.start_line   = head.start_line;
  assign out_ch.start_column = head.start_column;
  assign out_ch.token_length = head.token_length;
  assign out_ch.run_end      = head.run_end;

endmodule

/* rtl/lts_core.sv */
// scanner state and the per-character token decision
`timescale 1ns / 1ps

module lts_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [lts_pkg::CHAR_BITS-1:0] char_code,
  input  logic                          final_char,
  output lts_pkg::push_t                push
);
  import lts_pkg::*;

  // scan modes
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_COMMENT = 4'd1;
  localparam logic [3:0] M_PLUS    = 4'd2;
  localparam logic [3:0] M_MINUS   = 4'd3;
  localparam logic [3:0] M_LT      = 4'd4;
  localparam logic [3:0] M_GT      = 4'd5;
  localparam logic [3:0] M_EQ      = 4'd6;
  localparam logic [3:0] M_BANG    = 4'd7;
  localparam logic [3:0] M_NUMBER  = 4'd8;
  localparam logic [3:0] M_STRING  = 4'd9;
  localparam logic [3:0] M_SYMBOL  = 4'd10;

  typedef struct packed {
    logic                 v;
    logic [KIND_BITS-1:0] kind;
    logic [ERR_BITS-1:0]  err;
  } flush_t;

  // record a pending mode produces when it ends without extension
  function automatic flush_t flush_rec(logic [3:0] mode, logic bad, logic ewp);
    flush_t f;
    f.v    = 1'b1;
    f.kind = K_ERROR;
    f.err  = ERR_NONE;
    case (mode)
      M_PLUS:   f.kind = K_PLUS;
      M_MINUS:  f.kind = K_MINUS;
      M_LT:     f.kind = K_LT;
      M_GT:     f.kind = K_GT;
      M_EQ:     f.err  = ERR_INVALID;
      M_BANG:   f.err  = ERR_INVALID;
      M_SYMBOL: f.kind = K_SYMBOL;
      M_STRING: f.err  = ERR_OPEN_STR;
      M_NUMBER: begin
        if (bad) begin
          f.err = ERR_MULTI_PT;
        end else if (ewp) begin
          f.err = ERR_TRAIL_PT;
        end else begin
          f.kind = K_NUMBER;
        end
      end
      default:  f.v = 1'b0;
    endcase
    return f;
  endfunction

  // state registers
  logic [3:0]             mode_r, mode_nxt;
  logic                   seen_point_r, seen_point_nxt;
  logic                   number_bad_r, number_bad_nxt;
  logic                   ends_point_r, ends_point_nxt;
  logic [LINE_BITS-1:0]   tok_line_r, tok_line_nxt;
  logic [COLUMN_BITS-1:0] tok_col_r, tok_col_nxt;
  logic [LEN_BITS-1:0]    tok_len_r, tok_len_nxt;
  logic [LINE_BITS-1:0]   cur_line_r, cur_line_nxt;
  logic [COLUMN_BITS-1:0] cur_col_r, cur_col_nxt;

  // character classes
  logic is_digit, is_alpha, is_space, is_point, num_ch, sym_ch;

  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_alpha = ((char_code >= CH_LO_A) && (char_code <= CH_LO_Z)) ||
                    ((char_code >= CH_UP_A) && (char_code <= CH_UP_Z));
  assign is_space = (char_code == CH_SPACE) ||
                    ((char_code >= CH_TAB) && (char_code <= CH_CR));
  assign is_point = (char_code == CH_POINT);
  assign num_ch   = is_digit || is_point;
  assign sym_ch   = is_alpha || is_digit || (char_code == CH_MINUS) ||
                    (char_code == CH_UNDER);

  // intermediate values of the three phases
  logic                   taken;
  flush_t                 fl_a, fl_c;
  logic                   a_v, b_v, c_v;
  logic [KIND_BITS-1:0]   a_kind, b_kind;
  logic [ERR_BITS-1:0]    a_err, b_err;
  logic [3:0]             mode1, mode2;
  logic                   seen1, bad1, ewp1, seen2, bad2, ewp2;
  logic [LEN_BITS-1:0]    len_grow, len1, len2;
  logic [LINE_BITS-1:0]   tl2;
  logic [COLUMN_BITS-1:0] tc2;
  result_t                rec_a, rec_b, rec_c;

  assign len_grow = (tok_len_r == '1) ? tok_len_r : tok_len_r + LEN_ONE;
  assign fl_a     = flush_rec(mode_r, number_bad_r, ends_point_r);

  // phase a: extend or close the pending token
  always_comb begin
    taken  = 1'b0;
    a_v    = 1'b0;
    a_kind = fl_a.kind;
    a_err  = fl_a.err;
    mode1  = mode_r;
    seen1  = seen_point_r;
    bad1   = number_bad_r;
    ewp1   = ends_point_r;
    len1   = tok_len_r;
    case (mode_r)
      M_COMMENT: begin
        taken = 1'b1;
        if (char_code == CH_LF) mode1 = M_IDLE;
      end
      M_PLUS, M_MINUS: begin
        if (num_ch) begin
          taken = 1'b1;
          mode1 = M_NUMBER;
          seen1 = is_point;
          ewp1  = is_point;
          bad1  = 1'b0;
          len1  = len_grow;
        end else begin
          a_v   = 1'b1;
          mode1 = M_IDLE;
        end
      end
      M_LT, M_GT, M_EQ, M_BANG: begin
        a_v   = 1'b1;
        mode1 = M_IDLE;
        if (char_code == CH_EQUAL) begin
          taken  = 1'b1;
          len1   = len_grow;
          a_err  = ERR_NONE;
          a_kind = (mode_r == M_LT) ? K_LEQ :
                   (mode_r == M_GT) ? K_GEQ :
                   (mode_r == M_EQ) ? K_EQ  : K_NEQ;
        end
      end
      M_NUMBER: begin
        if (num_ch) begin
          taken = 1'b1;
          len1  = len_grow;
          ewp1  = is_point;
          if (is_point) begin
            seen1 = 1'b1;
            bad1  = number_bad_r || seen_point_r;
          end
        end else begin
          a_v   = 1'b1;
          mode1 = M_IDLE;
        end
      end
      M_STRING: begin
        taken = 1'b1;
        len1  = len_grow;
        if (char_code == CH_DQUOTE) begin
          a_v    = 1'b1;
          a_kind = K_STRING;
          a_err  = ERR_NONE;
          mode1  = M_IDLE;
        end
      end
      M_SYMBOL: begin
        if (sym_ch) begin
          taken = 1'b1;
          len1  = len_grow;
        end else begin
          a_v   = 1'b1;
          mode1 = M_IDLE;
        end
      end
      default: mode1 = M_IDLE;
    endcase
  end

  // phase b: scan a character that starts a new token
  always_comb begin
    tl2    = tok_line_r;
    tc2    = tok_col_r;
    len2   = len1;
    mode2  = mode1;
    seen2  = seen1;
    bad2   = bad1;
    ewp2   = ewp1;
    b_v    = 1'b0;
    b_kind = K_ERROR;
    b_err  = ERR_NONE;
    if (!taken) begin
      tl2  = cur_line_r;
      tc2  = cur_col_r;
      len2 = LEN_ONE;
      if (!is_space) begin
        case (char_code)
          CH_SEMI:   mode2 = M_COMMENT;
          CH_LPAREN: begin b_v = 1'b1; b_kind = K_OPEN;    end
          CH_RPAREN: begin b_v = 1'b1; b_kind = K_CLOSE;   end
          CH_SQUOTE: begin b_v = 1'b1; b_kind = K_QUOTE;   end
          CH_STAR:   begin b_v = 1'b1; b_kind = K_STAR;    end
          CH_SLASH:  begin b_v = 1'b1; b_kind = K_SLASH;   end
          CH_PCT:    begin b_v = 1'b1; b_kind = K_PERCENT; end
          CH_PLUS:   mode2 = M_PLUS;
          CH_MINUS:  mode2 = M_MINUS;
          CH_LT:     mode2 = M_LT;
          CH_GT:     mode2 = M_GT;
          CH_EQUAL:  mode2 = M_EQ;
          CH_BANG:   mode2 = M_BANG;
          CH_DQUOTE: mode2 = M_STRING;
          default: begin
            if (num_ch) begin
              mode2 = M_NUMBER;
              seen2 = is_point;
              ewp2  = is_point;
              bad2  = 1'b0;
            end else if (is_alpha) begin
              mode2 = M_SYMBOL;
            end else begin
              b_v   = 1'b1;
              b_err = ERR_INVALID;
            end
          end
        endcase
      end
    end
  end

  // phase c: flush on the final character, then advance the position
  assign fl_c = flush_rec(mode2, bad2, ewp2);
  assign c_v  = final_char && fl_c.v;

  always_comb begin
    tok_line_nxt = tl2;
    tok_col_nxt  = tc2;
    tok_len_nxt  = len2;
    if (final_char) begin
      mode_nxt       = M_IDLE;
      seen_point_nxt = 1'b0;
      number_bad_nxt = 1'b0;
      ends_point_nxt = 1'b0;
      cur_line_nxt   = LINE_ONE;
      cur_col_nxt    = COL_ONE;
    end else begin
      mode_nxt       = mode2;
      seen_point_nxt = seen2;
      number_bad_nxt = bad2;
      ends_point_nxt = ewp2;
      if (char_code == CH_LF) begin
        cur_line_nxt = (cur_line_r == '1) ? cur_line_r : cur_line_r + LINE_ONE;
        cur_col_nxt  = COL_ONE;
      end else begin
        cur_line_nxt = cur_line_r;
        cur_col_nxt  = (cur_col_r == '1) ? cur_col_r : cur_col_r + COL_ONE;
      end
    end
  end

  // record assembly and packing into at most two slots
  always_comb begin
    rec_a = '{token_kind: a_kind, error_code: a_err, start_line: tok_line_r,
              start_column: tok_col_r, token_length: len1, run_end: 1'b0};
    rec_b = '{token_kind: b_kind, error_code: b_err, start_line: cur_line_r,
              start_column: cur_col_r, token_length: LEN_ONE, run_end: 1'b0};
    rec_c = '{token_kind: fl_c.kind, error_code: fl_c.err, start_line: tl2,
              start_column: tc2, token_length: len2, run_end: 1'b0};
    push.valid0 = go && (a_v || b_v || c_v);
    push.valid1 = go && ((a_v && (b_v || c_v)) || (b_v && c_v));
    push.res0   = a_v ? rec_a : (b_v ? rec_b : rec_c);
    push.res1   = (a_v && b_v) ? rec_b : rec_c;
    push.res0.run_end = !push.valid1;
    push.res1.run_end = 1'b1;
  end

  // state update, one character per go
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_IDLE;
      seen_point_r <= 1'b0;
      number_bad_r <= 1'b0;
      ends_point_r <= 1'b0;
      tok_line_r   <= LINE_ONE;
      tok_col_r    <= COL_ONE;
      tok_len_r    <= '0;
      cur_line_r   <= LINE_ONE;
      cur_col_r    <= COL_ONE;
    end else if (go) begin
      mode_r       <= mode_nxt;
      seen_point_r <= seen_point_nxt;
      number_bad_r <= number_bad_nxt;
      ends_point_r <= ends_point_nxt;
      tok_line_r   <= tok_line_nxt;
      tok_col_r    <= tok_col_nxt;
      tok_len_r    <= tok_len_nxt;
      cur_line_r   <= cur_line_nxt;
      cur_col_r    <= cur_col_nxt;
    end
  end

`ifndef SYNTHESIS
  // the final character leaves the scanner at the start of a fresh input
  a_final_restart: assert property (@(posedge clk) disable iff (!rst_n)
    go && final_char |=> mode_r == M_IDLE && cur_line_r == LINE_ONE && cur_col_r == COL_ONE)
    else $error("scanner not restarted after final character");

  // positions are one-based
  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cur_line_r != '0 && cur_col_r != '0)
    else $error("current position reached zero");

  // a pending token always holds at least its first character
  a_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != M_IDLE |-> tok_len_r != '0)
    else $error("pending token with zero length");

  // a second decimal point implies a first one
  a_point_flags: assert property (@(posedge clk) disable iff (!rst_n)
    number_bad_r |-> seen_point_r)
    else $error("multiple-point flag without a point");
`endif

endmodule

/* rtl/lts_out_queue.sv */
// small result queue taking up to two token records per cycle
`timescale 1ns / 1ps

module lts_out_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  lts_pkg::push_t   push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output lts_pkg::result_t out_res
);
  import lts_pkg::*;

  result_t           entry_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              pop;
  logic [QPTR_W-1:0] wptr_p1;

  // room for the worst case of two records
  assign room      = count_r <= QCNT_W'(QDEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_res   = entry_r[rptr_r];
  assign pop       = out_valid && out_ready;
  assign wptr_p1   = wptr_r + QPTR_W'(1);

  // pointer and fill bookkeeping
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push.valid1) begin
      wptr_nxt = wptr_r + QPTR_W'(2);
    end else if (push.valid0) begin
      wptr_nxt = wptr_p1;
    end
    if (pop) rptr_nxt = rptr_r + QPTR_W'(1);
    count_nxt = count_r + QCNT_W'(push.valid0) + QCNT_W'(push.valid1) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    if (push.valid0) entry_r[wptr_r]  <= push.res0;
    if (push.valid1) entry_r[wptr_p1] <= push.res1;
  end

`ifndef SYNTHESIS
  // fill never exceeds the depth
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  // records are only written when there is room for a pair
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid0 |-> room)
    else $error("records pushed without room");

  // a second record never comes without a first
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid1 |-> push.valid0)
    else $error("second record without first");
`endif

endmodule
